>>> hdl/dsn_pkg.sv
package dsn_pkg;

    localparam int CHAR_W = 8;
    localparam int ACC_W  = 47;
    localparam int MANT_W = 48;
    localparam int FRAC_W = 4;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

    typedef enum logic [2:0] {
        PH_LEAD = 3'b001,
        PH_INT  = 3'b010,
        PH_FRAC = 3'b100
    } t_phase;

    typedef struct packed {
        t_phase              phase;
        logic                negative;
        logic [ACC_W-1:0]    acc;
        logic [FRAC_W-1:0]   frac;
        logic                err;
    } t_state;

    typedef struct packed {
        logic signed [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0]        fraction_digits;
        logic                     invalid;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:    PH_LEAD,
        negative: 1'b0,
        acc:      '0,
        frac:     '0,
        err:      1'b0
    };

endpackage

>>> hdl/dsn_if.sv
interface dsn_char_if;
    import dsn_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dsn_result_if;
    import dsn_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0]        fraction_digits;
    logic                     invalid;

    modport source (output valid, output mantissa, output fraction_digits,
                    output invalid, input ready);
    modport sink   (input valid, input mantissa, input fraction_digits,
                    input invalid, output ready);
endinterface

>>> hdl/dsn_step.sv
module dsn_step #(
    parameter int MAX_LEN = 15,
    parameter int CNT_W   = 4
) (
    input  dsn_pkg::t_state             i_state,
    input  logic [CNT_W-1:0]            i_cnt,
    input  logic [dsn_pkg::CHAR_W-1:0]  i_char_code,
    input  logic                        i_last_char,
    output dsn_pkg::t_state             o_state,
    output logic [CNT_W-1:0]            o_cnt,
    output dsn_pkg::t_result            o_result
);
    import dsn_pkg::*;

    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(MAX_LEN);

    logic                  first;
    logic [CNT_W-1:0]      cnt_inc;
    logic                  is_digit;
    logic                  is_space;
    logic [ACC_W+3:0]      acc_sum;
    logic                  acc_ovf;
    t_state                s;
    logic [MANT_W-1:0]     mag;

    // acc * 10 + digit, wide enough that the overflow shows in the top bits
    assign acc_sum = {1'b0, i_state.acc, 3'b000} + {3'b000, i_state.acc, 1'b0}
                   + {(ACC_W)'(0), i_char_code[3:0]};
    assign acc_ovf = |acc_sum[ACC_W+3:ACC_W];

    assign first    = (i_cnt == '0);
    assign is_digit = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign is_space = (i_char_code == CHAR_SPACE)
                   || ((i_char_code >= CHAR_TAB) && (i_char_code <= CHAR_CR));

    always_comb begin
        s       = i_state;
        cnt_inc = (i_cnt < CNT_LIM) ? i_cnt + CNT_W'(1) : i_cnt;
        if (cnt_inc == CNT_LIM) begin
            s.err = 1'b1;
        end

        priority if (is_digit) begin
            if (acc_ovf) begin
                s.acc = '1;
                s.err = 1'b1;
            end else begin
                s.acc = acc_sum[ACC_W-1:0];
            end
            if (i_state.phase == PH_FRAC) begin
                if (i_state.frac != FRAC_MAX) begin
                    s.frac = i_state.frac + FRAC_W'(1);
                end else begin
                    s.err = 1'b1;
                end
            end else begin
                s.phase = PH_INT;
            end
        end else if (i_char_code == CHAR_DOT) begin
            if (first || (i_state.phase == PH_FRAC)) begin
                s.err = 1'b1;
            end else begin
                s.phase = PH_FRAC;
            end
        end else if (i_char_code == CHAR_MINUS) begin
            if (i_state.phase == PH_LEAD) begin
                s.negative = 1'b1;
                s.phase    = PH_INT;
            end else begin
                s.err = 1'b1;
            end
        end else if (is_space) begin
            if (i_state.phase != PH_LEAD) begin
                s.err = 1'b1;
            end
        end else begin
            s.err = 1'b1;
        end
    end

    assign mag = {1'b0, s.acc};

    always_comb begin
        if (s.err) begin
            o_result = '{mantissa: '0, fraction_digits: '0, invalid: 1'b1};
        end else begin
            o_result.mantissa        = s.negative ? -mag : mag;
            o_result.fraction_digits = s.frac;
            o_result.invalid         = 1'b0;
        end
    end

    // the string's end returns everything to the idle state
    assign o_state = i_last_char ? STATE_RESET : s;
    assign o_cnt   = i_last_char ? '0 : cnt_inc;

endmodule

>>> hdl/decimal_string_to_scaled_number_top.sv
// a final character goes from the input register to the result register on o_res
// throughput: one character per cycle unless stalled, set by the state update
// between the input register and the state/result registers
// a waiting result stalls only final characters, others keep flowing
// reset: synchronous active-low i_rst_n clears valids and parser state
module decimal_string_to_scaled_number_top #(
    parameter int MAX_LEN = 15
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dsn_char_if.sink       i_chr,
    dsn_result_if.source   o_res
);
    import dsn_pkg::*;

    // count saturates at the length limit, which is all the check needs
    localparam int CNT_W = $clog2(MAX_LEN + 1);

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic              r_in_last;

    // parser state
    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;

    // output register
    logic              r_out_valid;
    t_result           r_out;

    t_state            n_state;
    logic [CNT_W-1:0]  n_cnt;
    t_result           n_out;

    logic out_free;
    logic advance;

    // a final character needs a free output slot, others never wait
    assign out_free = !r_out_valid || o_res.ready;
    assign advance  = r_in_valid && (!r_in_last || out_free);

    assign i_chr.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_chr.ready) begin
            r_in_valid <= i_chr.valid;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_chr.valid && i_chr.ready) begin
            r_in_char <= i_chr.char_code;
            r_in_last <= i_chr.last_char;
        end
    end

    dsn_step #(
        .MAX_LEN (MAX_LEN),
        .CNT_W   (CNT_W)
    ) u_dsn_step (
        .i_state     (r_state),
        .i_cnt       (r_cnt),
        .i_char_code (r_in_char),
        .i_last_char (r_in_last),
        .o_state     (n_state),
        .o_cnt       (n_cnt),
        .o_result    (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
            r_cnt   <= '0;
        end else if (advance) begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // result slot: filled by a final character, drained by a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.mantissa        = r_out.mantissa;
    assign o_res.fraction_digits = r_out.fraction_digits;
    assign o_res.invalid         = r_out.invalid;

endmodule

>>> hdl/dsn_checker.sv
module dsn_checker #(
    parameter int MAX_LEN = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [dsn_pkg::MANT_W-1:0]  i_mantissa,
    input  logic [dsn_pkg::FRAC_W-1:0]         i_fraction_digits,
    input  logic                               i_invalid
);
    import dsn_pkg::*;

    // a waiting result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_mantissa) && $stable(i_fraction_digits)
             && $stable(i_invalid)))
        else $error("result changed while stalled");

    // flagged results carry zero fields
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_invalid) |-> ((i_mantissa == '0) && (i_fraction_digits == '0)))
        else $error("invalid result with nonzero fields");

    // a good string is shorter than the limit and holds a character before the dot
    a_frac_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_invalid) |->
            ((i_fraction_digits == '0) || ((int'(i_fraction_digits) + 3) <= MAX_LEN)))
        else $error("fraction digit count beyond string length");

    // nothing pending right after reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !i_out_valid)
        else $error("result valid straight out of reset");

endmodule

bind decimal_string_to_scaled_number_top dsn_checker #(
    .MAX_LEN (MAX_LEN)
) u_dsn_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_res.valid),
    .i_out_ready       (o_res.ready),
    .i_mantissa        (o_res.mantissa),
    .i_fraction_digits (o_res.fraction_digits),
    .i_invalid         (o_res.invalid)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dsn_pkg::*;

    localparam int MAX_LEN = 15;

    // character values outside the package's named set
    localparam logic [CHAR_W-1:0] CHAR_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_ALL_ONES = 8'hFF;

    localparam logic [63:0] MAGNITUDE_LIMIT = (64'd1 << ACC_W) - 64'd1;
    localparam logic [4:0]  COUNT_LIMIT     = 5'd31;

    localparam int IDLE_PERCENT = 38;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int TARGET_CHARS = 1000;

    typedef struct {
        logic [CHAR_W-1:0] code;
        logic              last;
    } t_char_item;

    typedef logic [CHAR_W-1:0] t_text[$];

    logic i_clk;
    logic i_rst_n;

    dsn_char_if   chr_if ();
    dsn_result_if res_if ();

    decimal_string_to_scaled_number_top #(
        .MAX_LEN (MAX_LEN)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr_if),
        .o_res   (res_if)
    );

    // characters waiting to be driven and numbers waiting to come out
    t_char_item char_queue[$];
    t_result    expected_numbers[$];
    t_char_item next_char;

    int chars_driven;
    int mismatches;
    int stall_cycles;

    // parser copy kept by the testbench
    t_phase            parse_phase;
    logic              is_negative;
    logic [ACC_W-1:0]  magnitude;
    logic [FRAC_W-1:0] frac_seen;
    logic [4:0]        seen_chars;
    logic              bad_string;

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // random idling, switched off over a stretch in the middle of the run
    function automatic logic take_break();
        if (chars_driven >= 300 && chars_driven < 500) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PERCENT;
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic [CHAR_W-1:0] random_blank();
        if ($urandom_range(0, 5) == 0) begin
            return CHAR_SPACE;
        end
        return CHAR_TAB + CHAR_W'($urandom_range(0, 4));
    endfunction

    function automatic logic [CHAR_W-1:0] random_digit();
        return CHAR_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    task automatic clear_parser();
        parse_phase = PH_LEAD;
        is_negative = 1'b0;
        magnitude   = '0;
        frac_seen   = '0;
        seen_chars  = '0;
        bad_string  = 1'b0;
    endtask

    // advance the parser by one transferred character, queue a number on the last one
    task automatic convert_char(input logic [CHAR_W-1:0] c, input logic last);
        logic              first;
        logic [63:0]       digit;
        logic [63:0]       wide;
        logic [MANT_W-1:0] signed_value;
        t_result           number;
        first = (seen_chars == '0);
        if (seen_chars != COUNT_LIMIT) begin
            seen_chars = seen_chars + 5'd1;
        end
        if (int'(seen_chars) >= MAX_LEN) begin
            bad_string = 1'b1;
        end

        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            digit = 64'(c - CHAR_ZERO);
            wide  = 64'(magnitude);
            // saturate the digits instead of wrapping
            if (wide > (MAGNITUDE_LIMIT - digit) / 64'd10) begin
                magnitude  = MAGNITUDE_LIMIT[ACC_W-1:0];
                bad_string = 1'b1;
            end else begin
                wide      = wide * 64'd10 + digit;
                magnitude = wide[ACC_W-1:0];
            end
            if (parse_phase == PH_FRAC) begin
                if (frac_seen != FRAC_MAX) begin
                    frac_seen = frac_seen + FRAC_W'(1);
                end else begin
                    bad_string = 1'b1;
                end
            end else begin
                parse_phase = PH_INT;
            end
        end else if (c == CHAR_DOT) begin
            // a dot may not open the string, and only one is allowed
            if (first || parse_phase == PH_FRAC) begin
                bad_string = 1'b1;
            end else begin
                parse_phase = PH_FRAC;
            end
        end else if (c == CHAR_MINUS) begin
            if (parse_phase == PH_LEAD) begin
                is_negative = 1'b1;
                parse_phase = PH_INT;
            end else begin
                bad_string = 1'b1;
            end
        end else if (is_blank(c)) begin
            if (parse_phase != PH_LEAD) begin
                bad_string = 1'b1;
            end
        end else begin
            bad_string = 1'b1;
        end

        if (last) begin
            if (bad_string) begin
                number.mantissa        = '0;
                number.fraction_digits = '0;
                number.invalid         = 1'b1;
            end else begin
                signed_value = {1'b0, magnitude};
                if (is_negative) begin
                    signed_value = -signed_value;
                end
                number.mantissa        = signed_value;
                number.fraction_digits = frac_seen;
                number.invalid         = 1'b0;
            end
            expected_numbers.push_back(number);
            clear_parser();
        end
    endtask

    task automatic push_char(input logic [CHAR_W-1:0] c, input logic last);
        t_char_item item;
        item.code = c;
        item.last = last;
        char_queue.push_back(item);
    endtask

    task automatic send_text(input t_text text);
        foreach (text[i]) begin
            push_char(text[i], i == text.size() - 1);
        end
    endtask

    task automatic add_text(input string s);
        t_text text;
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
        send_text(text);
    endtask

    // number-shaped string: blanks, sign, digits, dot, digits
    task automatic build_number(output t_text text);
        int  int_digits;
        int  frac_digits;
        logic with_dot;
        logic all_nines;
        text = {};
        if ($urandom_range(0, 9) == 0) begin
            // near the length limit
            int_digits  = $urandom_range(8, 16);
            frac_digits = $urandom_range(0, 16 - int_digits);
            with_dot    = frac_digits != 0 || $urandom_range(0, 1) != 0;
            all_nines   = 1'($urandom_range(0, 1));
        end else begin
            int_digits  = $urandom_range(0, 6);
            frac_digits = $urandom_range(0, 6);
            with_dot    = 1'($urandom_range(0, 1));
            all_nines   = 1'b0;
        end
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0) begin
            text.push_back(random_blank());
        end
        if ($urandom_range(0, 1)) begin
            text.push_back(CHAR_MINUS);
        end
        repeat (int_digits) begin
            text.push_back(all_nines ? CHAR_NINE : random_digit());
        end
        if (with_dot) begin
            text.push_back(CHAR_DOT);
            repeat (frac_digits) begin
                text.push_back(all_nines ? CHAR_NINE : random_digit());
            end
        end
        if (text.size() == 0) begin
            text.push_back(random_digit());
        end
    endtask

    task automatic add_random_string();
        t_text text;
        int    pick;
        int    spot;
        logic [CHAR_W-1:0] stray;
        pick = $urandom_range(0, 99);
        if (pick < 88) begin
            build_number(text);
        end else begin
            // plain noise
            text = {};
            repeat ($urandom_range(1, 5)) begin
                text.push_back(CHAR_W'($urandom_range(0, 255)));
            end
        end
        if (pick >= 70 && pick < 88) begin
            // broken number: a misplaced or foreign character
            case ($urandom_range(0, 3))
                0:       stray = CHAR_MINUS;
                1:       stray = CHAR_DOT;
                2:       stray = random_blank();
                default: stray = CHAR_W'($urandom_range(0, 255));
            endcase
            spot = $urandom_range(0, text.size() - 1);
            if ($urandom_range(0, 1)) begin
                text[spot] = stray;
            end else begin
                text.insert(spot, stray);
            end
        end
        send_text(text);
    endtask

    // character driver, holds valid until the transfer completes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chr_if.valid <= 1'b0;
        end else if (!chr_if.valid || chr_if.ready) begin
            if (char_queue.size() != 0 && !take_break()) begin
                next_char = char_queue.pop_front();
                chr_if.valid     <= 1'b1;
                chr_if.char_code <= next_char.code;
                chr_if.last_char <= next_char.last;
                chars_driven++;
            end else begin
                chr_if.valid <= 1'b0;
            end
        end
    end

    // character monitor feeds the parser copy
    always @(posedge i_clk) begin
        if (i_rst_n && chr_if.valid && chr_if.ready) begin
            convert_char(chr_if.char_code, chr_if.last_char);
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= !take_break();
        end
    end

    // result monitor, in-order compare against the oldest expected number
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_numbers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: mantissa %0d frac %0d invalid %0b",
                             res_if.mantissa, res_if.fraction_digits, res_if.invalid);
                end
            end else begin
                want = expected_numbers.pop_front();
                if (res_if.mantissa !== want.mantissa
                        || res_if.fraction_digits !== want.fraction_digits
                        || res_if.invalid !== want.invalid) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result mismatch: expected mantissa %0d frac %0d invalid %0b,",
                                 want.mantissa, want.fraction_digits, want.invalid);
                        $display("                 got mantissa %0d frac %0d invalid %0b",
                                 res_if.mantissa, res_if.fraction_digits, res_if.invalid);
                    end
                end
            end
        end
    end

    // cycles without any transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (chr_if.valid && chr_if.ready) || (res_if.valid && res_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) begin
            @(negedge i_clk);
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        chars_driven = 0;
        mismatches   = 0;
        stall_cycles = 0;
        clear_parser();

        // every input known from time zero
        i_rst_n          = 1'b0;
        chr_if.valid     = 1'b0;
        chr_if.char_code = CHAR_NUL;
        chr_if.last_char = 1'b0;
        res_if.ready     = 1'b0;

        // directed strings
        push_char(CHAR_TAB, 1'b0);
        add_text("-9.0");                       // blank then sign, digits, dot
        add_text(".");                          // dot opening the string
        add_text("1..");                        // second dot
        push_char(CHAR_NUL, 1'b1);              // stray, lowest code
        push_char(CHAR_ALL_ONES, 1'b1);         // stray, highest code
        push_char(CHAR_SPACE, 1'b1);            // blank only, no digits
        add_text("-");                          // sign only
        add_text("-.");                         // sign and dot, no digits
        add_text("5-");                         // sign after digits
        add_text("1 ");                         // blank after digits
        for (logic [CHAR_W-1:0] c = CHAR_TAB + CHAR_W'(1); c <= CHAR_CR; c++) begin
            push_char(c, 1'b0);                 // rest of the blank codes
        end
        push_char(CHAR_ZERO + 8'd7, 1'b1);

        // random strings, mostly number-shaped
        while (char_queue.size() < TARGET_CHARS + 24) begin
            add_random_string();
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: all characters sent and every number returned
        do begin
            @(negedge i_clk);
        end while (char_queue.size() != 0 || chr_if.valid || expected_numbers.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
